FILE: design/cmfb_pkg.sv
// Shared types and constants of the column-major frame blitter.
package cmfb_pkg;

  localparam int CURSOR_W    = 17;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_BEGIN  = 3'd1;
  localparam logic [2:0] CMD_DATA   = 3'd2;
  localparam logic [2:0] CMD_INVERT = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;

  localparam logic [7:0] FILL_BYTE = 8'hFF;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLEAR,
    OP_BEGIN,
    OP_DATA,
    OP_INVERT,
    OP_READ
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_IGNORED  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_DONE     = 2'd3
  } status_t;

  typedef struct packed {
    op_t                 op;
    logic [CURSOR_W-1:0] base;
    logic [7:0]          rect_width;
    logic [7:0]          rect_height;
    logic [7:0]          frame_height;
    logic [7:0]          data_byte;
    logic [12:0]         address;
    logic [12:0]         clear_count;
    logic                oob;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

FILE: design/cmfb_if.sv
// Handshake interfaces for the command beats and the result beats.
interface cmfb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [7:0]  top;
  logic [7:0]  column;
  logic [7:0]  rect_width;
  logic [7:0]  rect_height;
  logic [7:0]  frame_height;
  logic [7:0]  data_byte;
  logic [12:0] address;
  logic [12:0] clear_count;

  modport source (
    output valid, command, top, column, rect_width, rect_height, frame_height,
           data_byte, address, clear_count,
    input  ready
  );
  modport sink (
    input  valid, command, top, column, rect_width, rect_height, frame_height,
           data_byte, address, clear_count,
    output ready
  );
endinterface

interface cmfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [1:0] status;
  logic       copy_active;

  modport source (output valid, read_data, status, copy_active, input ready);
  modport sink (input valid, read_data, status, copy_active, output ready);
endinterface

FILE: design/cmfb_front.sv
// Front end: accepts command beats, decodes them and computes start addresses.
module cmfb_front #(
  parameter int BUFFER_BYTES = 5000
) (
  cmfb_in_if.sink          in_ch,
  output cmfb_pkg::item_t  item,
  output logic             push,
  input  logic             q_full
);
  import cmfb_pkg::*;

  localparam logic [CURSOR_W-1:0] LIMIT = CURSOR_W'(BUFFER_BYTES);

  logic [15:0] prod;

  assign prod = in_ch.column * in_ch.frame_height;

  always_comb begin
    item.base         = CURSOR_W'(prod) + CURSOR_W'(in_ch.top);
    item.rect_width   = in_ch.rect_width;
    item.rect_height  = in_ch.rect_height;
    item.frame_height = in_ch.frame_height;
    item.data_byte    = in_ch.data_byte;
    item.address      = in_ch.address;
    item.clear_count  = in_ch.clear_count;
    item.oob          = 1'b0;
    case (in_ch.command)
      CMD_CLEAR: begin
        item.op  = OP_CLEAR;
        item.oob = CURSOR_W'(in_ch.clear_count) > LIMIT;
      end
      CMD_BEGIN:  item.op = OP_BEGIN;
      CMD_DATA:   item.op = OP_DATA;
      CMD_INVERT: item.op = OP_INVERT;
      CMD_READ: begin
        item.op  = OP_READ;
        item.oob = CURSOR_W'(in_ch.address) >= LIMIT;
      end
      default:    item.op = OP_NOP;
    endcase
  end

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

endmodule

FILE: design/cmfb_queue.sv
// Short queue of decoded commands between the front end and the back end.
module cmfb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cmfb_pkg::item_t   item,
  output logic              full,
  input  logic              pop,
  output cmfb_pkg::q_head_t head
);
  import cmfb_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);

  item_t         entries_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= item;
    end
  end

  assign full       = cnt_r == NW'(QUEUE_DEPTH);
  assign head.valid = cnt_r != '0;
  assign head.item  = entries_r[rd_ptr_r];

endmodule

FILE: design/cmfb_back.sv
// Back end: frame store, copy cursor, invert and clear walkers, result register.
module cmfb_back #(
  parameter int BUFFER_BYTES = 5000
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmfb_pkg::q_head_t head,
  output logic              pop,
  cmfb_out_if.source        out_ch
);
  import cmfb_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam logic [CURSOR_W-1:0] LIMIT = CURSOR_W'(BUFFER_BYTES);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_RD_WAIT = 5'b00010,
    S_INV_RD  = 5'b00100,
    S_INV_WR  = 5'b01000,
    S_CLR     = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [CURSOR_W-1:0] cursor_r, cursor_nxt;
  logic [7:0]          row_r, row_nxt;
  logic [7:0]          col_r, col_nxt;
  logic [7:0]          g_rh_r, g_rh_nxt;
  logic [7:0]          g_fh_r, g_fh_nxt;
  logic [7:0]          g_rw_r, g_rw_nxt;
  logic                busy_r, busy_nxt;

  logic [CURSOR_W-1:0] w_addr_r, w_addr_nxt;
  logic [CURSOR_W-1:0] w_end_r, w_end_nxt;
  status_t             w_st_r, w_st_nxt;
  logic [7:0]          i_row_r, i_row_nxt;
  logic [7:0]          i_col_r, i_col_nxt;
  logic [7:0]          i_rh_r, i_rh_nxt;
  logic [7:0]          i_rw_r, i_rw_nxt;
  logic [7:0]          i_fh_r, i_fh_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_rd_r, out_rd_nxt;
  status_t             out_st_r, out_st_nxt;
  logic                out_act_r, out_act_nxt;

  logic [7:0]          mem [BUFFER_BYTES];
  logic [7:0]          mem_q;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [7:0]          wdata;
  logic [AW-1:0]       raddr;

  logic                slot_free;
  logic                load;
  logic [7:0]          res_rd;
  status_t             res_st;

  logic [CURSOR_W-1:0] cur_inc, cur_jump, w_inc, w_jump, clr_n;
  logic [7:0]          row_inc, col_inc, i_row_inc, i_col_inc;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign cur_inc   = cursor_r + CURSOR_W'(1);
  assign cur_jump  = cur_inc + CURSOR_W'(g_fh_r) - CURSOR_W'(g_rh_r);
  assign w_inc     = w_addr_r + CURSOR_W'(1);
  assign w_jump    = w_inc + CURSOR_W'(i_fh_r) - CURSOR_W'(i_rh_r);
  assign row_inc   = row_r + 8'd1;
  assign col_inc   = col_r + 8'd1;
  assign i_row_inc = i_row_r + 8'd1;
  assign i_col_inc = i_col_r + 8'd1;
  assign clr_n     = head.item.oob ? LIMIT : CURSOR_W'(head.item.clear_count);

  always_comb begin
    state_nxt  = state_r;
    cursor_nxt = cursor_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    g_rh_nxt   = g_rh_r;
    g_fh_nxt   = g_fh_r;
    g_rw_nxt   = g_rw_r;
    busy_nxt   = busy_r;
    w_addr_nxt = w_addr_r;
    w_end_nxt  = w_end_r;
    w_st_nxt   = w_st_r;
    i_row_nxt  = i_row_r;
    i_col_nxt  = i_col_r;
    i_rh_nxt   = i_rh_r;
    i_rw_nxt   = i_rw_r;
    i_fh_nxt   = i_fh_r;
    pop        = 1'b0;
    we         = 1'b0;
    waddr      = w_addr_r[AW-1:0];
    wdata      = FILL_BYTE;
    raddr      = w_addr_r[AW-1:0];
    load       = 1'b0;
    res_rd     = 8'd0;
    res_st     = ST_OK;

    case (state_r)
      S_IDLE: begin
        if (head.valid && slot_free) begin
          pop = 1'b1;
          case (head.item.op)
            OP_CLEAR: begin
              w_st_nxt = head.item.oob ? ST_OVERFLOW : ST_OK;
              if (clr_n == '0) begin
                load = 1'b1;
              end else begin
                w_addr_nxt = '0;
                w_end_nxt  = clr_n;
                state_nxt  = S_CLR;
              end
            end
            OP_BEGIN: begin
              cursor_nxt = head.item.base;
              row_nxt    = 8'd0;
              col_nxt    = 8'd0;
              g_rh_nxt   = head.item.rect_height;
              g_fh_nxt   = head.item.frame_height;
              g_rw_nxt   = head.item.rect_width;
              busy_nxt   = (head.item.rect_width != 8'd0) &&
                           (head.item.rect_height != 8'd0);
              load       = 1'b1;
              res_st     = busy_nxt ? ST_OK : ST_DONE;
            end
            OP_DATA: begin
              load = 1'b1;
              if (!busy_r) begin
                res_st = ST_IGNORED;
              end else if (cursor_r >= LIMIT) begin
                busy_nxt = 1'b0;
                res_st   = ST_OVERFLOW;
              end else begin
                we    = 1'b1;
                waddr = cursor_r[AW-1:0];
                wdata = head.item.data_byte;
                if (row_inc >= g_rh_r) begin
                  row_nxt    = 8'd0;
                  cursor_nxt = cur_jump;
                  col_nxt    = col_inc;
                  if (col_inc >= g_rw_r) begin
                    busy_nxt = 1'b0;
                    res_st   = ST_DONE;
                  end
                end else begin
                  row_nxt    = row_inc;
                  cursor_nxt = cur_inc;
                end
              end
            end
            OP_INVERT: begin
              if (head.item.rect_width == 8'd0 || head.item.rect_height == 8'd0) begin
                load = 1'b1;
              end else begin
                w_addr_nxt = head.item.base;
                i_row_nxt  = 8'd0;
                i_col_nxt  = 8'd0;
                i_rh_nxt   = head.item.rect_height;
                i_rw_nxt   = head.item.rect_width;
                i_fh_nxt   = head.item.frame_height;
                state_nxt  = S_INV_RD;
              end
            end
            OP_READ: begin
              if (head.item.oob) begin
                load   = 1'b1;
                res_st = ST_OVERFLOW;
              end else begin
                raddr     = AW'(CURSOR_W'(head.item.address));
                state_nxt = S_RD_WAIT;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        load      = 1'b1;
        res_rd    = mem_q;
        state_nxt = S_IDLE;
      end
      S_INV_RD: begin
        if (w_addr_r >= LIMIT) begin
          load      = 1'b1;
          res_st    = ST_OVERFLOW;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_INV_WR;
        end
      end
      S_INV_WR: begin
        we        = 1'b1;
        wdata     = mem_q ^ FILL_BYTE;
        state_nxt = S_INV_RD;
        if (i_row_inc == i_rh_r) begin
          i_row_nxt  = 8'd0;
          i_col_nxt  = i_col_inc;
          w_addr_nxt = w_jump;
          if (i_col_inc == i_rw_r) begin
            load      = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          i_row_nxt  = i_row_inc;
          w_addr_nxt = w_inc;
        end
      end
      S_CLR: begin
        we         = 1'b1;
        w_addr_nxt = w_inc;
        if (w_inc == w_end_r) begin
          load      = 1'b1;
          res_st    = w_st_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    out_rd_nxt    = out_rd_r;
    out_st_nxt    = out_st_r;
    out_act_nxt   = out_act_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_rd_nxt    = res_rd;
      out_st_nxt    = res_st;
      out_act_nxt   = busy_nxt;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_r    <= '0;
      row_r       <= '0;
      col_r       <= '0;
      g_rh_r      <= '0;
      g_fh_r      <= '0;
      g_rw_r      <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      g_rh_r      <= g_rh_nxt;
      g_fh_r      <= g_fh_nxt;
      g_rw_r      <= g_rw_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_addr_r  <= w_addr_nxt;
    w_end_r   <= w_end_nxt;
    w_st_r    <= w_st_nxt;
    i_row_r   <= i_row_nxt;
    i_col_r   <= i_col_nxt;
    i_rh_r    <= i_rh_nxt;
    i_rw_r    <= i_rw_nxt;
    i_fh_r    <= i_fh_nxt;
    out_rd_r  <= out_rd_nxt;
    out_st_r  <= out_st_nxt;
    out_act_r <= out_act_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_data   = out_rd_r;
  assign out_ch.status      = out_st_r;
  assign out_ch.copy_active = out_act_r;

endmodule

FILE: design/column_major_frame_blitter_top.sv
// Top level of the column-major frame blitter: front end, command queue and back end.
// Each command beat yields exactly one result beat. Begin copy, copy data bytes, stray
// bytes, unused commands and reads outside the store finish in the idle state of the back
// end, so a copy streams one data byte per cycle while results are taken; a read inside
// the store waits in S_RD_WAIT for the registered frame store read. Invert takes the
// command, then for each byte reads it and writes back the inverted byte through the
// single write port, ending with an overflow status if it reaches the end of the store.
// Clear takes the command, then writes the fill byte to each address in turn. A two-beat
// queue decouples the input from the back end and takes new beats while an earlier result
// waits in the result register. The frame store has no clearing pass after reset: a byte
// that was never written reads back as an unknown value.
module column_major_frame_blitter_top #(
  parameter int BUFFER_BYTES = 5000
) (
  input  logic        clk,
  input  logic        rst_n,
  cmfb_in_if.sink     in_ch,
  cmfb_out_if.source  out_ch
);
  import cmfb_pkg::*;

  item_t   item;
  logic    push;
  logic    q_full;
  q_head_t head;
  logic    pop;

  cmfb_front #(.BUFFER_BYTES(BUFFER_BYTES)) u_front (
    .in_ch  (in_ch),
    .item   (item),
    .push   (push),
    .q_full (q_full)
  );

  cmfb_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .item  (item),
    .full  (q_full),
    .pop   (pop),
    .head  (head)
  );

  cmfb_back #(.BUFFER_BYTES(BUFFER_BYTES)) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

  a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("Back end took a command from an empty queue.");

  a_ignored_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_IGNORED) |-> !out_ch.copy_active)
    else $error("An ignored data beat reported an active copy.");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_DONE) |-> !out_ch.copy_active)
    else $error("A finished copy still reported itself active.");

  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.read_data != 8'd0) |-> out_ch.status == ST_OK)
    else $error("Nonzero read data came with a status other than ok.");

endmodule
